### rtl/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants for the text-mode cursor writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int ColW  = $clog2(COLUMNS);
  localparam int RowW  = $clog2(ROWS + 1);   // row saturates at ROWS
  localparam int AddrW = 11;
  localparam int CalcNeedW = $clog2(ROWS * COLUMNS + 1);
  localparam int AddrCalcW = (CalcNeedW > AddrW) ? CalcNeedW : AddrW;

  localparam int CharW  = 8;
  localparam int ColorW = 8;
  localparam int ValueW = CharW + ColorW;

  // Character codes
  localparam logic [CharW-1:0]  CodeNewline   = 8'h0A;
  localparam logic [CharW-1:0]  CodeTab       = 8'h09;
  localparam logic [CharW-1:0]  CodeBackspace = 8'h08;
  localparam logic [CharW-1:0]  CodeSpace     = 8'h20;
  localparam logic [ColorW-1:0] AttrWhite     = 8'd15;

  localparam int TabCount = 4;
  localparam int TabCntW  = $clog2(TabCount);

  // Command queue depth (power of two)
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_TAB,
    OP_BKSP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CharW-1:0]  code;
    logic [ColorW-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [ColW-1:0]    col;
    logic [TabCntW-1:0] tab_cnt;
  } back_stat_t;

endpackage

### rtl/tmcw_if.sv
// ----------------------------------------------------------------------------
// tmcw_char_if / tmcw_cell_if
// Valid/ready channels for character words in and cell-write words out.
// ----------------------------------------------------------------------------
interface tmcw_char_if;
  logic                          valid;
  logic                          ready;
  logic [tmcw_pkg::CharW-1:0]    char_code;
  logic [tmcw_pkg::ColorW-1:0]   char_color;

  modport source (output valid, output char_code, output char_color, input ready);
  modport sink   (input valid, input char_code, input char_color, output ready);
endinterface

interface tmcw_cell_if;
  logic                          valid;
  logic                          ready;
  logic [tmcw_pkg::AddrW-1:0]    cell_address;
  logic [tmcw_pkg::ValueW-1:0]   cell_value;
  logic                          last_write;

  modport source (output valid, output cell_address, output cell_value,
                  output last_write, input ready);
  modport sink   (input valid, input cell_address, input cell_value,
                  input last_write, output ready);
endinterface

### rtl/tmcw_front.sv
// ----------------------------------------------------------------------------
// tmcw_front
// Accepts character words, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module tmcw_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     char_code_i,
  input  logic [7:0]     char_color_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output tmcw_pkg::cmd_t cmd_o
);

  tmcw_pkg::cmd_t cmd_in;
  tmcw_pkg::cmd_t mem_q [tmcw_pkg::QDepth];

  logic [tmcw_pkg::QPtrW:0] wr_ptr_q, wr_ptr_d;
  logic [tmcw_pkg::QPtrW:0] rd_ptr_q, rd_ptr_d;
  logic                     full, empty, push, pop;

  // Tab and backspace always write a white space
  always_comb begin
    cmd_in.code  = tmcw_pkg::CodeSpace;
    cmd_in.color = tmcw_pkg::AttrWhite;
    unique case (char_code_i)
      tmcw_pkg::CodeNewline:   cmd_in.op = tmcw_pkg::OP_NEWLINE;
      tmcw_pkg::CodeTab:       cmd_in.op = tmcw_pkg::OP_TAB;
      tmcw_pkg::CodeBackspace: cmd_in.op = tmcw_pkg::OP_BKSP;
      default: begin
        cmd_in.op    = tmcw_pkg::OP_PRINT;
        cmd_in.code  = char_code_i;
        cmd_in.color = char_color_i;
      end
    endcase
  end

  assign empty = (wr_ptr_q == rd_ptr_q);
  assign full  = (wr_ptr_q[tmcw_pkg::QPtrW-1:0] == rd_ptr_q[tmcw_pkg::QPtrW-1:0]) &&
                 (wr_ptr_q[tmcw_pkg::QPtrW] != rd_ptr_q[tmcw_pkg::QPtrW]);

  assign in_ready_o  = !full;
  assign cmd_valid_o = !empty;
  assign push        = in_valid_i && !full;
  assign pop         = cmd_ready_i && !empty;
  assign cmd_o       = mem_q[rd_ptr_q[tmcw_pkg::QPtrW-1:0]];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q[tmcw_pkg::QPtrW-1:0]] <= cmd_in;
    end
  end

endmodule

### rtl/tmcw_back.sv
// ----------------------------------------------------------------------------
// tmcw_back
// Owns the cursor and carries out queued commands, one cell step per cycle
// unless a write is held by a full output stage, into a registered output stage.
// ----------------------------------------------------------------------------
module tmcw_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  tmcw_pkg::cmd_t               cmd_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tmcw_pkg::AddrW-1:0]   cell_address_o,
  output logic [tmcw_pkg::ValueW-1:0]  cell_value_o,
  output logic                         last_write_o,
  output tmcw_pkg::back_stat_t         stat_o
);

  localparam logic [tmcw_pkg::RowW-1:0] RowSat  = tmcw_pkg::RowW'(tmcw_pkg::ROWS);
  localparam logic [tmcw_pkg::ColW-1:0] ColLast = tmcw_pkg::ColW'(tmcw_pkg::COLUMNS - 1);
  localparam logic [tmcw_pkg::TabCntW-1:0] TabLast =
    tmcw_pkg::TabCntW'(tmcw_pkg::TabCount - 1);

  logic [tmcw_pkg::RowW-1:0]    row_q, row_d, row_inc, wr_row;
  logic [tmcw_pkg::ColW-1:0]    col_q, col_d, wr_col;
  logic [tmcw_pkg::TabCntW-1:0] tab_cnt_q, tab_cnt_d;
  logic                         wr, last, step_done, fire, out_free;
  logic [tmcw_pkg::AddrCalcW-1:0] addr_full;

  logic                         out_valid_q, out_valid_d;
  logic [tmcw_pkg::AddrW-1:0]   addr_q;
  logic [tmcw_pkg::ValueW-1:0]  value_q;
  logic                         last_q;

  // One cell step of the current command
  always_comb begin
    row_inc   = (row_q == RowSat) ? row_q : row_q + tmcw_pkg::RowW'(1);
    row_d     = row_q;
    col_d     = col_q;
    wr_row    = row_q;
    wr_col    = col_q;
    wr        = 1'b0;
    last      = 1'b1;
    step_done = 1'b1;
    unique case (cmd_i.op) inside
      tmcw_pkg::OP_PRINT, tmcw_pkg::OP_TAB: begin
        wr    = (row_q != RowSat);
        col_d = (col_q == ColLast) ? '0 : col_q + tmcw_pkg::ColW'(1);
        row_d = (col_q == ColLast) ? row_inc : row_q;
        if (cmd_i.op == tmcw_pkg::OP_TAB) begin
          step_done = (tab_cnt_q == TabLast);
          // later spaces past the bottom row are dropped
          last      = step_done || (row_d == RowSat);
        end
      end
      tmcw_pkg::OP_NEWLINE: begin
        row_d = row_inc;
        col_d = '0;
      end
      tmcw_pkg::OP_BKSP: begin
        if (!(row_q == '0 && col_q == '0)) begin
          if (col_q == '0) begin
            row_d = row_q - tmcw_pkg::RowW'(1);
            col_d = ColLast;
          end else begin
            col_d = col_q - tmcw_pkg::ColW'(1);
          end
          wr_row = row_d;
          wr_col = col_d;
          wr     = (row_d != RowSat);
        end
      end
      default: ;
    endcase
  end

  assign addr_full = tmcw_pkg::AddrCalcW'(wr_row) * tmcw_pkg::AddrCalcW'(tmcw_pkg::COLUMNS) +
                     tmcw_pkg::AddrCalcW'(wr_col);

  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && (!wr || out_free);
  assign cmd_ready_o = fire && step_done;

  always_comb begin
    tab_cnt_d = tab_cnt_q;
    if (fire) begin
      tab_cnt_d = step_done ? '0 : tab_cnt_q + tmcw_pkg::TabCntW'(1);
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = fire && wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      tab_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      tab_cnt_q   <= tab_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && wr) begin
      addr_q  <= addr_full[tmcw_pkg::AddrW-1:0];
      value_q <= {cmd_i.color, cmd_i.code};
      last_q  <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_address_o = addr_q;
  assign cell_value_o   = value_q;
  assign last_write_o   = last_q;

  assign stat_o.row     = row_q;
  assign stat_o.col     = col_q;
  assign stat_o.tab_cnt = tab_cnt_q;

endmodule

### rtl/text_mode_cursor_writer.sv
// ----------------------------------------------------------------------------
// A cell write passes through the command queue and then the registered
// output stage. Back end: one cell step per cycle unless a write is held by a
// full output stage; a tab is one step per space, other commands one step.
// The input side is held off only when the 2-entry command queue is full.
// Reset: cursor at row 0, column 0; queue and output stage empty.
// ----------------------------------------------------------------------------
// text_mode_cursor_writer
// Turns character words into text-cell writes while tracking the cursor.
// ----------------------------------------------------------------------------
module text_mode_cursor_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmcw_char_if.sink   char_i,
  tmcw_cell_if.source cell_o
);

  logic                 cmd_valid, cmd_ready;
  tmcw_pkg::cmd_t       cmd;
  tmcw_pkg::back_stat_t stat;

  tmcw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (char_i.valid),
    .in_ready_o   (char_i.ready),
    .char_code_i  (char_i.char_code),
    .char_color_i (char_i.char_color),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  tmcw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_o    (cmd_ready),
    .cmd_i          (cmd),
    .out_valid_o    (cell_o.valid),
    .out_ready_i    (cell_o.ready),
    .cell_address_o (cell_o.cell_address),
    .cell_value_o   (cell_o.cell_value),
    .last_write_o   (cell_o.last_write),
    .stat_o         (stat)
  );

  a_cursor_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.row <= tmcw_pkg::RowW'(tmcw_pkg::ROWS)) &&
    (stat.col <= tmcw_pkg::ColW'(tmcw_pkg::COLUMNS - 1)))
    else $error("cursor out of range");

  a_tab_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.tab_cnt != '0) |-> (cmd_valid && cmd.op == tmcw_pkg::OP_TAB))
    else $error("tab step count without a tab command");

  a_tab_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |=> (stat.tab_cnt == '0))
    else $error("tab step count not cleared after command");

endmodule
